/* hw/rtl/hgpw_pkg.sv */
// ----------------------------------------------------------------------------
// hgpw_pkg
// Shared constants, register codes and pipeline types of the gradient writer.
// ----------------------------------------------------------------------------
`default_nettype none

package hgpw_pkg;

   localparam int CoordWidth     = 12;
   localparam int PitchWidth     = 16;
   localparam int ScreenWidth    = 13;
   localparam int ColorWidth     = 24;
   localparam int ChanWidth      = 8;
   localparam int NumChans       = ColorWidth / ChanWidth;
   localparam int FracWidth      = 8;
   localparam int OffsetWidth    = 26;
   localparam int ProdWidth      = CoordWidth + PitchWidth;
   localparam int CmpWidth       = CoordWidth + ScreenWidth;
   localparam int CsrIndexWidth  = 3;
   localparam int CsrDataWidth   = 24;
   localparam int ReqDataWidth   = ((2 * CoordWidth + 7) / 8) * 8;
   localparam int RspDataWidth   = ((OffsetWidth + ColorWidth + 7) / 8) * 8;
   localparam int DivStepsPerStage = 2;
   localparam int NumDivStages   = FracWidth / DivStepsPerStage;
   localparam int PipeDepth      = NumDivStages + 1;

   typedef enum logic [CsrIndexWidth-1:0] {
      RegSpanStart,
      RegSpanWidth,
      RegStartColor,
      RegEndColor,
      RegScreenCols,
      RegScreenRows,
      RegRowPitch,
      RegDrawEnable
   } csr_index_type;

   typedef struct packed {
      logic [CoordWidth-1:0]  span_start_x;
      logic [CoordWidth-1:0]  span_width;
      logic [ColorWidth-1:0]  start_color;
      logic [ColorWidth-1:0]  end_color;
      logic [ScreenWidth-1:0] screen_columns;
      logic [ScreenWidth-1:0] screen_rows;
      logic [PitchWidth-1:0]  row_pitch_bytes;
      logic                   draw_enable;
   } cfg_type;

   typedef struct packed {
      logic                   ok;
      logic [CoordWidth-1:0]  col;
      logic [CoordWidth-1:0]  row;
      logic [CoordWidth-1:0]  rem;
      logic [FracWidth-1:0]   quo;
      logic [ProdWidth-1:0]   prod;
      logic [OffsetWidth-1:0] offset;
   } stage_type;

   typedef struct packed {
      logic                   write_valid;
      logic [OffsetWidth-1:0] word_offset;
      logic [ColorWidth-1:0]  pixel_color;
   } rsp_type;

endpackage

`default_nettype wire

/* hw/rtl/horizontal_gradient_pixel_writer.sv */
// ----------------------------------------------------------------------------
// horizontal_gradient_pixel_writer
// Clips a pixel against screen and gradient span, blends its colour, and
// forms its framebuffer word offset.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one pixel coordinate per transfer, rsp_* one result per
//   pixel in the same order: a write flag in rsp_tuser, and word offset and
//   colour in rsp_tdata (both zero when the pixel is clipped or disabled).
//   csr_* writes the eight span, colour, screen and pitch registers; write
//   them only while no pixel is in flight.
//   Throughput is one pixel per clock while the receiver keeps up. A result
//   reaches rsp_tvalid through one entry stage, four divider stages of two
//   quotient bits each for the blend fraction (row times pitch and the
//   offset add ride along in the first two), and one blend stage that
//   feeds the output register.
//   When the receiver stalls, the output register and one skid entry hold
//   results and the whole pipeline freezes; req_tready comes from a
//   register and drops once the skid entry fills. Nothing is lost or sent
//   twice. Reset drops all in-flight pixels and clears the configuration.
// ----------------------------------------------------------------------------
`default_nettype none

module horizontal_gradient_pixel_writer (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // request: pixel_col, pixel_row
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   input  wire logic [hgpw_pkg::ReqDataWidth-1:0]   req_tdata,
   // response
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   // word_offset, pixel_color
   output logic      [hgpw_pkg::RspDataWidth-1:0]   rsp_tdata,
   // write_valid
   output logic                                     rsp_tuser,
   // configuration
   input  wire logic                                csr_we,
   input  wire logic [hgpw_pkg::CsrIndexWidth-1:0]  csr_index,
   input  wire logic [hgpw_pkg::CsrDataWidth-1:0]   csr_wdata
);

   hgpw_pkg::cfg_type   cfg;
   hgpw_pkg::stage_type pipe_ff [hgpw_pkg::PipeDepth];
   hgpw_pkg::stage_type pipe_in [hgpw_pkg::PipeDepth];
   logic [hgpw_pkg::PipeDepth-1:0] valid_ff;
   logic [hgpw_pkg::PipeDepth-1:0] valid_in;
   logic [hgpw_pkg::CoordWidth-1:0] div_rem [hgpw_pkg::NumDivStages];
   logic [hgpw_pkg::FracWidth-1:0]  div_quo [hgpw_pkg::NumDivStages];
   hgpw_pkg::rsp_type   res_ff;
   hgpw_pkg::rsp_type   res_in;
   hgpw_pkg::rsp_type   rsp_data;
   logic                res_valid_ff;
   logic                skid_ready;
   logic                en;
   logic [hgpw_pkg::CoordWidth-1:0] req_col;
   logic [hgpw_pkg::CoordWidth-1:0] req_row;
   logic [hgpw_pkg::CoordWidth:0]   span_end;
   logic [hgpw_pkg::ColorWidth-1:0] blend_color;

   hgpw_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   assign en         = skid_ready;
   assign req_tready = en;
   assign req_col    = req_tdata[hgpw_pkg::CoordWidth-1:0];
   assign req_row    = req_tdata[2*hgpw_pkg::CoordWidth-1:hgpw_pkg::CoordWidth];
   // span end without wrap
   assign span_end   = {1'b0, cfg.span_start_x} + {1'b0, cfg.span_width};

   for (genvar k = 0; k < hgpw_pkg::NumDivStages; k++) begin : g_div
      hgpw_div_step u_div_step (
         .rem_i   (pipe_ff[k].rem),
         .quo_i   (pipe_ff[k].quo),
         .divisor (cfg.span_width),
         .rem_o   (div_rem[k]),
         .quo_o   (div_quo[k])
      );
   end

   always_comb begin
      pipe_in[0].ok = cfg.draw_enable
         && (hgpw_pkg::CmpWidth'(req_col) < hgpw_pkg::CmpWidth'(cfg.screen_columns))
         && (hgpw_pkg::CmpWidth'(req_row) < hgpw_pkg::CmpWidth'(cfg.screen_rows))
         && (cfg.span_width != '0)
         && (req_col >= cfg.span_start_x)
         && ({1'b0, req_col} < span_end);
      pipe_in[0].col    = req_col;
      pipe_in[0].row    = req_row;
      pipe_in[0].rem    = req_col - cfg.span_start_x;
      pipe_in[0].quo    = '0;
      pipe_in[0].prod   = '0;
      pipe_in[0].offset = '0;
      for (int k = 1; k < hgpw_pkg::PipeDepth; k++) begin
         pipe_in[k]     = pipe_ff[k-1];
         pipe_in[k].rem = div_rem[k-1];
         pipe_in[k].quo = div_quo[k-1];
      end
      pipe_in[1].prod = hgpw_pkg::ProdWidth'(pipe_ff[0].row)
                      * hgpw_pkg::ProdWidth'(cfg.row_pitch_bytes);
      // pitch in bytes over four gives words per row
      pipe_in[2].offset = hgpw_pkg::OffsetWidth'(
         {2'b00, pipe_ff[1].prod[hgpw_pkg::ProdWidth-1:2]}
         + hgpw_pkg::ProdWidth'(pipe_ff[1].col));
   end

   always_comb begin
      valid_in[0] = req_tvalid && req_tready;
      for (int k = 1; k < hgpw_pkg::PipeDepth; k++) begin
         valid_in[k] = valid_ff[k-1];
      end
   end

   hgpw_blend u_blend (
      .frac    (pipe_ff[hgpw_pkg::PipeDepth-1].quo),
      .color_a (cfg.start_color),
      .color_b (cfg.end_color),
      .color_o (blend_color)
   );

   always_comb begin
      res_in.write_valid = pipe_ff[hgpw_pkg::PipeDepth-1].ok;
      res_in.word_offset = '0;
      res_in.pixel_color = '0;
      if (pipe_ff[hgpw_pkg::PipeDepth-1].ok) begin
         res_in.word_offset = pipe_ff[hgpw_pkg::PipeDepth-1].offset;
         res_in.pixel_color = blend_color;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         res_valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff     <= valid_in;
         res_valid_ff <= valid_ff[hgpw_pkg::PipeDepth-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pipe_ff <= pipe_in;
         res_ff  <= res_in;
      end
   end

   hgpw_skid u_skid (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (res_valid_ff && en),
      .in_ready  (skid_ready),
      .in_data   (res_ff),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rsp_data)
   );

   assign rsp_tuser = rsp_data.write_valid;
   assign rsp_tdata = hgpw_pkg::RspDataWidth'({rsp_data.pixel_color, rsp_data.word_offset});

   // a clipped pixel carries no offset and no colour
   a_clipped_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata == '0)
      else $error("clipped pixel with nonzero payload");

   // back-pressure toward the source only while a result is held
   a_stall_held: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid)
      else $error("request stalled with empty output");

   // the last pipeline stage always moves into the blend stage when enabled
   a_pipe_advance: assert property (@(posedge clock) disable iff (reset)
      en && valid_ff[hgpw_pkg::PipeDepth-1] |=> res_valid_ff)
      else $error("pixel dropped between pipeline and blend stage");

endmodule

`default_nettype wire

/* hw/rtl/hgpw_csr.sv */
// ----------------------------------------------------------------------------
// hgpw_csr
// Configuration registers, written through a plain index/data write port.
// ----------------------------------------------------------------------------
`default_nettype none

module hgpw_csr (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_we,
   input  wire logic [hgpw_pkg::CsrIndexWidth-1:0]  csr_index,
   input  wire logic [hgpw_pkg::CsrDataWidth-1:0]   csr_wdata,
   output hgpw_pkg::cfg_type                        cfg
);

   hgpw_pkg::cfg_type cfg_ff;
   hgpw_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (hgpw_pkg::csr_index_type'(csr_index))
            hgpw_pkg::RegSpanStart: begin
               cfg_in.span_start_x = csr_wdata[hgpw_pkg::CoordWidth-1:0];
            end
            hgpw_pkg::RegSpanWidth: begin
               cfg_in.span_width = csr_wdata[hgpw_pkg::CoordWidth-1:0];
            end
            hgpw_pkg::RegStartColor: begin
               cfg_in.start_color = csr_wdata[hgpw_pkg::ColorWidth-1:0];
            end
            hgpw_pkg::RegEndColor: begin
               cfg_in.end_color = csr_wdata[hgpw_pkg::ColorWidth-1:0];
            end
            hgpw_pkg::RegScreenCols: begin
               cfg_in.screen_columns = csr_wdata[hgpw_pkg::ScreenWidth-1:0];
            end
            hgpw_pkg::RegScreenRows: begin
               cfg_in.screen_rows = csr_wdata[hgpw_pkg::ScreenWidth-1:0];
            end
            hgpw_pkg::RegRowPitch: begin
               cfg_in.row_pitch_bytes = csr_wdata[hgpw_pkg::PitchWidth-1:0];
            end
            hgpw_pkg::RegDrawEnable: begin
               cfg_in.draw_enable = csr_wdata[0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

/* hw/rtl/hgpw_div_step.sv */
// ----------------------------------------------------------------------------
// hgpw_div_step
// Restoring division steps for the blend fraction, two quotient bits a stage.
// ----------------------------------------------------------------------------
`default_nettype none

module hgpw_div_step (
   input  wire logic [hgpw_pkg::CoordWidth-1:0] rem_i,
   input  wire logic [hgpw_pkg::FracWidth-1:0]  quo_i,
   input  wire logic [hgpw_pkg::CoordWidth-1:0] divisor,
   output logic      [hgpw_pkg::CoordWidth-1:0] rem_o,
   output logic      [hgpw_pkg::FracWidth-1:0]  quo_o
);

   logic [hgpw_pkg::CoordWidth-1:0] r_v;
   logic [hgpw_pkg::FracWidth-1:0]  q_v;
   logic [hgpw_pkg::CoordWidth:0]   dbl_v;

   // remainder stays below the divisor, so the doubled value fits one extra bit
   always_comb begin
      r_v   = rem_i;
      q_v   = quo_i;
      dbl_v = '0;
      for (int i = 0; i < hgpw_pkg::DivStepsPerStage; i++) begin
         dbl_v = {r_v, 1'b0};
         if (dbl_v >= {1'b0, divisor}) begin
            r_v = hgpw_pkg::CoordWidth'(dbl_v - {1'b0, divisor});
            q_v = {q_v[hgpw_pkg::FracWidth-2:0], 1'b1};
         end else begin
            r_v = dbl_v[hgpw_pkg::CoordWidth-1:0];
            q_v = {q_v[hgpw_pkg::FracWidth-2:0], 1'b0};
         end
      end
   end

   assign rem_o = r_v;
   assign quo_o = q_v;

endmodule

`default_nettype wire

/* hw/rtl/hgpw_blend.sv */
// ----------------------------------------------------------------------------
// hgpw_blend
// Per-channel linear blend of two RGB888 colours by an 8-bit fraction.
// ----------------------------------------------------------------------------
`default_nettype none

module hgpw_blend (
   input  wire logic [hgpw_pkg::FracWidth-1:0]  frac,
   input  wire logic [hgpw_pkg::ColorWidth-1:0] color_a,
   input  wire logic [hgpw_pkg::ColorWidth-1:0] color_b,
   output logic      [hgpw_pkg::ColorWidth-1:0] color_o
);

   function automatic logic [hgpw_pkg::ChanWidth-1:0] blend_chan(
      input logic [hgpw_pkg::ChanWidth-1:0] a,
      input logic [hgpw_pkg::ChanWidth-1:0] b,
      input logic [hgpw_pkg::FracWidth-1:0] t
   );
      logic [hgpw_pkg::FracWidth:0]                       inv;
      logic [hgpw_pkg::ChanWidth+hgpw_pkg::FracWidth:0]   pa;
      logic [hgpw_pkg::ChanWidth+hgpw_pkg::FracWidth-1:0] pb;
      logic [hgpw_pkg::ChanWidth:0]                       sum;
      inv = (hgpw_pkg::FracWidth+1)'(1 << hgpw_pkg::FracWidth) - {1'b0, t};
      pa  = (hgpw_pkg::ChanWidth+hgpw_pkg::FracWidth+1)'(a)
          * (hgpw_pkg::ChanWidth+hgpw_pkg::FracWidth+1)'(inv);
      pb  = (hgpw_pkg::ChanWidth+hgpw_pkg::FracWidth)'(b)
          * (hgpw_pkg::ChanWidth+hgpw_pkg::FracWidth)'(t);
      // each term truncated on its own before the add
      sum = pa[hgpw_pkg::ChanWidth+hgpw_pkg::FracWidth:hgpw_pkg::FracWidth]
          + {1'b0, pb[hgpw_pkg::ChanWidth+hgpw_pkg::FracWidth-1:hgpw_pkg::FracWidth]};
      return sum[hgpw_pkg::ChanWidth-1:0];
   endfunction

   always_comb begin
      for (int c = 0; c < hgpw_pkg::NumChans; c++) begin
         color_o[c*hgpw_pkg::ChanWidth +: hgpw_pkg::ChanWidth] =
            blend_chan(color_a[c*hgpw_pkg::ChanWidth +: hgpw_pkg::ChanWidth],
                       color_b[c*hgpw_pkg::ChanWidth +: hgpw_pkg::ChanWidth],
                       frac);
      end
   end

endmodule

`default_nettype wire

/* hw/rtl/hgpw_skid.sv */
// ----------------------------------------------------------------------------
// hgpw_skid
// Output register with a skid entry, so ready toward the pipeline is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module hgpw_skid (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   output logic                   in_ready,
   input  wire hgpw_pkg::rsp_type in_data,
   output logic                   out_valid,
   input  wire logic              out_ready,
   output hgpw_pkg::rsp_type      out_data
);

   logic              out_valid_ff;
   logic              out_valid_in;
   logic              skid_valid_ff;
   logic              skid_valid_in;
   hgpw_pkg::rsp_type out_data_ff;
   hgpw_pkg::rsp_type out_data_in;
   hgpw_pkg::rsp_type skid_data_ff;
   hgpw_pkg::rsp_type skid_data_in;
   logic              push;
   logic              pop;

   assign in_ready = !skid_valid_ff;
   assign push     = in_valid && !skid_valid_ff;
   assign pop      = out_valid_ff && out_ready;

   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_data_in   = out_data_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         if (pop) begin
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (push) begin
         if (!out_valid_ff || pop) begin
            out_data_in  = in_data;
            out_valid_in = 1'b1;
         end else begin
            // receiver stalled: park the transfer in the skid entry
            skid_data_in  = in_data;
            skid_valid_in = 1'b1;
         end
      end else if (pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

endmodule

`default_nettype wire

/* dv/tb_horizontal_gradient_pixel_writer.sv */
// ----------------------------------------------------------------------------
// tb_horizontal_gradient_pixel_writer
// Drives pixel coordinates through the gradient writer under several register
// settings, predicts the clip decision, word offset and blended colour of
// every pixel, and compares each response transfer in order.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_horizontal_gradient_pixel_writer;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CycleLimit    = 200000;
   localparam int SettleCycles  = 12;
   localparam int ItemsPerPhase = 134;
   localparam int NumPhases     = 6;
   localparam int HoldOffCycles = 300;

   // gradient model: register copy plus queue of pending pixel results
   class gradient_pixel_scoreboard;
      logic [hgpw_pkg::CoordWidth-1:0]  span_start_x;
      logic [hgpw_pkg::CoordWidth-1:0]  span_width;
      logic [hgpw_pkg::ColorWidth-1:0]  start_color;
      logic [hgpw_pkg::ColorWidth-1:0]  end_color;
      logic [hgpw_pkg::ScreenWidth-1:0] screen_columns;
      logic [hgpw_pkg::ScreenWidth-1:0] screen_rows;
      logic [hgpw_pkg::PitchWidth-1:0]  row_pitch_bytes;
      logic                             draw_enable;
      hgpw_pkg::rsp_type                expected_pixels[$];
      int unsigned                      mismatches;

      function new();
         span_start_x    = '0;
         span_width      = '0;
         start_color     = '0;
         end_color       = '0;
         screen_columns  = '0;
         screen_rows     = '0;
         row_pitch_bytes = '0;
         draw_enable     = 1'b0;
         mismatches      = 0;
      endfunction

      function void set_reg(hgpw_pkg::csr_index_type idx,
                            logic [hgpw_pkg::CsrDataWidth-1:0] value);
         case (idx)
            hgpw_pkg::RegSpanStart:  span_start_x    = value[hgpw_pkg::CoordWidth-1:0];
            hgpw_pkg::RegSpanWidth:  span_width      = value[hgpw_pkg::CoordWidth-1:0];
            hgpw_pkg::RegStartColor: start_color     = value[hgpw_pkg::ColorWidth-1:0];
            hgpw_pkg::RegEndColor:   end_color       = value[hgpw_pkg::ColorWidth-1:0];
            hgpw_pkg::RegScreenCols: screen_columns  = value[hgpw_pkg::ScreenWidth-1:0];
            hgpw_pkg::RegScreenRows: screen_rows     = value[hgpw_pkg::ScreenWidth-1:0];
            hgpw_pkg::RegRowPitch:   row_pitch_bytes = value[hgpw_pkg::PitchWidth-1:0];
            hgpw_pkg::RegDrawEnable: draw_enable     = value[0];
            default: ;
         endcase
      endfunction

      // each product term is truncated on its own
      function logic [hgpw_pkg::ChanWidth-1:0] mix_channel(
         logic [hgpw_pkg::ChanWidth-1:0] a,
         logic [hgpw_pkg::ChanWidth-1:0] b,
         int unsigned t);
         int unsigned sum;
         sum = ((32'(a) * (256 - t)) >> 8) + ((32'(b) * t) >> 8);
         return sum[hgpw_pkg::ChanWidth-1:0];
      endfunction

      function hgpw_pkg::rsp_type predict_pixel(logic [hgpw_pkg::CoordWidth-1:0] col,
                                                logic [hgpw_pkg::CoordWidth-1:0] row);
         hgpw_pkg::rsp_type res;
         int unsigned       c;
         int unsigned       r;
         int unsigned       s;
         int unsigned       w;
         int unsigned       t;
         longint unsigned   off;
         c = 32'(col);
         r = 32'(row);
         s = 32'(span_start_x);
         w = 32'(span_width);
         res = '0;
         // span end is formed without wrap
         if (draw_enable && c < 32'(screen_columns) && r < 32'(screen_rows) && w != 0
             && c >= s && c < s + w) begin
            t = ((c - s) * 256) / w;
            off = (64'(r) * 64'(row_pitch_bytes)) / 4 + 64'(c);
            res.write_valid = 1'b1;
            res.word_offset = off[hgpw_pkg::OffsetWidth-1:0];
            res.pixel_color = {mix_channel(start_color[23:16], end_color[23:16], t),
                               mix_channel(start_color[15:8], end_color[15:8], t),
                               mix_channel(start_color[7:0], end_color[7:0], t)};
         end
         return res;
      endfunction

      function void note_pixel(logic [hgpw_pkg::CoordWidth-1:0] col,
                               logic [hgpw_pkg::CoordWidth-1:0] row);
         expected_pixels.push_back(predict_pixel(col, row));
      endfunction

      function void flag(string what, longint unsigned got, longint unsigned want);
         mismatches++;
         if (mismatches <= 10)
            $display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got, want);
      endfunction

      function void check_result(logic tuser, logic [hgpw_pkg::RspDataWidth-1:0] tdata);
         hgpw_pkg::rsp_type want;
         if (expected_pixels.size() == 0) begin
            flag("unexpected response, tdata", 64'(tdata), 0);
            return;
         end
         want = expected_pixels.pop_front();
         if (tuser !== want.write_valid)
            flag("write_valid", 64'(tuser), 64'(want.write_valid));
         if (tdata[hgpw_pkg::OffsetWidth-1:0] !== want.word_offset)
            flag("word_offset", 64'(tdata[hgpw_pkg::OffsetWidth-1:0]),
                 64'(want.word_offset));
         if (tdata[hgpw_pkg::OffsetWidth +: hgpw_pkg::ColorWidth] !== want.pixel_color)
            flag("pixel_color", 64'(tdata[hgpw_pkg::OffsetWidth +: hgpw_pkg::ColorWidth]),
                 64'(want.pixel_color));
         if (tdata[hgpw_pkg::RspDataWidth-1:hgpw_pkg::OffsetWidth+hgpw_pkg::ColorWidth]
             !== '0)
            flag("tdata padding",
                 64'(tdata[hgpw_pkg::RspDataWidth-1:
                           hgpw_pkg::OffsetWidth+hgpw_pkg::ColorWidth]), 0);
      endfunction

      function int pending();
         return expected_pixels.size();
      endfunction
   endclass

   logic                                clock = 1'b0;
   logic                                reset = 1'b1;
   logic                                req_tvalid = 1'b0;
   logic                                req_tready;
   logic [hgpw_pkg::ReqDataWidth-1:0]   req_tdata = '0;
   logic                                rsp_tvalid;
   logic                                rsp_tready = 1'b0;
   logic [hgpw_pkg::RspDataWidth-1:0]   rsp_tdata;
   logic                                rsp_tuser;
   logic                                csr_we = 1'b0;
   logic [hgpw_pkg::CsrIndexWidth-1:0]  csr_index = '0;
   logic [hgpw_pkg::CsrDataWidth-1:0]   csr_wdata = '0;

   gradient_pixel_scoreboard sb = new();

   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;
   int unsigned hold_off_request = 0;
   int unsigned cycle_count = 0;

   horizontal_gradient_pixel_writer dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // pixel_col, pixel_row
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),   // word_offset, pixel_color
      .rsp_tuser  (rsp_tuser),   // write_valid
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("** horizontal_gradient_pixel_writer: FAILED **");
         $finish;
      end
   end

   // receiver: checks each transfer, then picks the next tready
   initial begin : receiver
      int unsigned hold_left;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready)
            sb.check_result(rsp_tuser, rsp_tdata);
         if (hold_off_request != 0) begin
            hold_left = hold_off_request;
            hold_off_request = 0;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
         end
      end
   end

   task automatic send_pixel(logic [hgpw_pkg::CoordWidth-1:0] col,
                             logic [hgpw_pkg::CoordWidth-1:0] row);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {row, col};
      do @(posedge clock); while (!req_tready);
      sb.note_pixel(col, row);
   endtask

   task automatic write_reg(hgpw_pkg::csr_index_type idx,
                            logic [hgpw_pkg::CsrDataWidth-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      sb.set_reg(idx, value);
      @(posedge clock);
   endtask

   // only called with nothing in flight
   task automatic load_config(logic [11:0] start_x, logic [11:0] width,
                              logic [23:0] c_start, logic [23:0] c_end,
                              logic [12:0] cols, logic [12:0] rows,
                              logic [15:0] pitch, logic enable);
      write_reg(hgpw_pkg::RegSpanStart, hgpw_pkg::CsrDataWidth'(start_x));
      write_reg(hgpw_pkg::RegSpanWidth, hgpw_pkg::CsrDataWidth'(width));
      write_reg(hgpw_pkg::RegStartColor, c_start);
      write_reg(hgpw_pkg::RegEndColor, c_end);
      write_reg(hgpw_pkg::RegScreenCols, hgpw_pkg::CsrDataWidth'(cols));
      write_reg(hgpw_pkg::RegScreenRows, hgpw_pkg::CsrDataWidth'(rows));
      write_reg(hgpw_pkg::RegRowPitch, hgpw_pkg::CsrDataWidth'(pitch));
      write_reg(hgpw_pkg::RegDrawEnable, hgpw_pkg::CsrDataWidth'(enable));
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic random_config();
      int unsigned start_x;
      int unsigned width;
      int unsigned cols;
      int unsigned rows;
      int unsigned pick;
      start_x = ($urandom_range(0, 9) < 3) ? $urandom_range(0, 63) : $urandom_range(0, 4095);
      pick = $urandom_range(0, 19);
      if (pick == 0)
         width = 0;
      else if (pick < 10)
         width = $urandom_range(1, 300);
      else
         width = $urandom_range(1, 4095);
      pick = $urandom_range(0, 9);
      cols = (pick == 0) ? $urandom_range(4097, 8191) :
             (pick == 1) ? 4096 : $urandom_range(0, 4096);
      pick = $urandom_range(0, 9);
      rows = (pick == 0) ? $urandom_range(4097, 8191) :
             (pick == 1) ? 4096 : $urandom_range(0, 4096);
      load_config(12'(start_x), 12'(width), 24'($urandom_range(0, 24'hFFFFFF)),
                  24'($urandom_range(0, 24'hFFFFFF)), 13'(cols), 13'(rows),
                  16'($urandom_range(0, 65535)), $urandom_range(0, 9) != 0);
   endtask

   // mostly pixels that land in the span and on screen, the rest anywhere
   task automatic random_pixel();
      int unsigned lo;
      int unsigned hi;
      int unsigned col;
      int unsigned row;
      col = $urandom_range(0, 4095);
      row = $urandom_range(0, 4095);
      if ($urandom_range(0, 3) != 0) begin
         lo = 32'(sb.span_start_x);
         hi = lo + 32'(sb.span_width) - 1;
         if (hi > 4095) hi = 4095;
         if (sb.screen_columns != 0 && hi > 32'(sb.screen_columns) - 1)
            hi = 32'(sb.screen_columns) - 1;
         if (sb.span_width != 0 && lo <= hi)
            col = $urandom_range(lo, hi);
         if (sb.screen_rows != 0)
            row = $urandom_range(0, (sb.screen_rows > 4096) ? 4095 :
                                    32'(sb.screen_rows) - 1);
      end
      send_pixel(12'(col), 12'(row));
   endtask

   initial begin : stimulus
      send_idle_pct = 9;
      recv_idle_pct = 57;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // span edges, screen edges, full-range colours
      load_config(12'd100, 12'd50, 24'hFF8000, 24'h00FFFF, 13'd640, 13'd480,
                  16'd2560, 1'b1);
      send_pixel(12'd99, 12'd10);
      send_pixel(12'd100, 12'd0);
      send_pixel(12'd101, 12'd479);
      send_pixel(12'd149, 12'd479);
      send_pixel(12'd150, 12'd5);
      send_pixel(12'd120, 12'd480);
      send_pixel(12'd0, 12'd0);
      send_pixel(12'd4095, 12'd4095);
      drain();
      // drawing disabled
      load_config(12'd0, 12'd4095, 24'hFFFFFF, 24'h000000, 13'd4096, 13'd4096,
                  16'd4096, 1'b0);
      send_pixel(12'd10, 12'd10);
      send_pixel(12'd4094, 12'd4095);
      drain();
      // zero span width
      load_config(12'd0, 12'd0, 24'hFFFFFF, 24'hFFFFFF, 13'd4096, 13'd4096,
                  16'd4096, 1'b1);
      send_pixel(12'd0, 12'd0);
      send_pixel(12'd2048, 12'd7);
      drain();
      // span past the last column, largest pitch, full screen
      load_config(12'd4095, 12'd4095, 24'hFFFFFF, 24'h000000, 13'd4096, 13'd4096,
                  16'd65535, 1'b1);
      send_pixel(12'd4095, 12'd4095);
      send_pixel(12'd4094, 12'd4095);
      send_pixel(12'd0, 12'd1);
      drain();
      // screen registers above the coordinate range, zero pitch
      load_config(12'd0, 12'd4095, 24'h000000, 24'hFFFFFF, 13'd8191, 13'd8191,
                  16'd0, 1'b1);
      send_pixel(12'd4094, 12'd4095);
      send_pixel(12'd1, 12'd3);
      drain();
      // empty screen
      load_config(12'd0, 12'd4095, 24'h123456, 24'hABCDEF, 13'd0, 13'd0,
                  16'd3, 1'b1);
      send_pixel(12'd0, 12'd0);
      drain();

      for (int p = 0; p < NumPhases; p++) begin
         case (p / 2)
            0: begin
               send_idle_pct = 9;
               recv_idle_pct = 57;
            end
            1: begin
               send_idle_pct = 57;
               recv_idle_pct = 9;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         random_config();
         // long receiver stall so the pipeline fills and req_tready drops
         if (p == 0)
            hold_off_request = HoldOffCycles;
         for (int i = 0; i < ItemsPerPhase; i++)
            random_pixel();
         drain();
      end

      if (sb.pending() == 0 && sb.mismatches == 0) begin
         $display("** horizontal_gradient_pixel_writer: PASSED **");
      end else begin
         $display("** horizontal_gradient_pixel_writer: FAILED **");
      end
      $finish;
   end

endmodule

`default_nettype wire
